/* hdl/rsmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmd_pkg - shared types for the rounded saturating multiply-divide block
// Holds the code that the front end attaches to each beat so that the back
// end knows whether to divide or to force a fixed answer.
// ----------------------------------------------------------------------------
package rsmd_pkg;

  // How the back end settles a beat.
  typedef enum logic [1:0] {
    KIND_DIVIDE = 2'd0,  // run the long division
    KIND_ZERO   = 2'd1,  // zero divisor with a zero factor
    KIND_ONES   = 2'd2   // zero divisor with nonzero factors, or overflow
  } kind_t;

  localparam int unsigned KIND_W = $bits(kind_t);

endpackage

/* hdl/rounded_saturating_muldiv_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_saturating_muldiv_top - rounded, saturating multiply then divide
// Returns (multiplicand * multiplier + divisor / 2) / divisor per beat,
// with the special answers for a zero divisor and for overflow.
// ----------------------------------------------------------------------------
// The block takes one beat of three unsigned operands per clock and returns
// one quotient beat per clock, in order, for as long as the result side keeps
// popping. Only the low OPERAND_WIDTH bits of each operand are used, and the
// quotient is zero-extended to 32 bits. A beat passes through the front
// end (the product, then the rounding bias and the checks), the middle
// queue and the divider, which resolves one quotient bit per stage. It then
// shows on the result ports as soon as it enters the result queue. A zero
// divisor gives zero when either factor is zero and all-ones otherwise; a
// quotient too wide for OPERAND_WIDTH bits gives all-ones. Halves round up.
// The front end and the divider stall on their own, each against the queue
// that follows it, so a brief hold-off on the result side does not stop
// intake at once. There is no configuration and no state carried between
// beats.
// ----------------------------------------------------------------------------
module rounded_saturating_muldiv_top #(
  parameter int unsigned OPERAND_WIDTH = 32,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_multiplicand,
  input  logic [31:0] in_multiplier,
  input  logic [31:0] in_divisor,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_quotient
);

  localparam int unsigned W       = OPERAND_WIDTH;
  localparam int unsigned MID_W   = rsmd_pkg::KIND_W + 3 * W;
  localparam int unsigned OUT_DEP = 2;

  // Front end to middle queue.
  logic            f_valid;
  logic            mid_full;
  rsmd_pkg::kind_t f_kind;
  logic [W-1:0]    f_hi, f_lo, f_div;

  // Middle queue to divider.
  logic             mid_empty;
  logic             mid_pop;
  logic [MID_W-1:0] mid_data;
  rsmd_pkg::kind_t  b_kind;
  logic [W-1:0]     b_hi, b_lo, b_div;

  // Divider to result queue.
  logic         r_valid;
  logic         res_full;
  logic [W-1:0] r_quot;
  logic [W-1:0] res_data;

  rsmd_front #(
    .W (W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .a        (in_multiplicand[W-1:0]),
    .b        (in_multiplier[W-1:0]),
    .d        (in_divisor[W-1:0]),
    .dn_valid (f_valid),
    .dn_ready (!mid_full),
    .dn_kind  (f_kind),
    .dn_hi    (f_hi),
    .dn_lo    (f_lo),
    .dn_div   (f_div)
  );

  rsmd_queue #(
    .DATA_W (MID_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_valid),
    .full    (mid_full),
    .wr_data ({f_kind, f_hi, f_lo, f_div}),
    .pop     (mid_pop),
    .empty   (mid_empty),
    .rd_data (mid_data)
  );

  // Unpack the head of the middle queue for the divider.
  assign b_kind = rsmd_pkg::kind_t'(mid_data[MID_W-1 -: rsmd_pkg::KIND_W]);
  assign b_hi   = mid_data[3*W-1 -: W];
  assign b_lo   = mid_data[2*W-1 -: W];
  assign b_div  = mid_data[W-1:0];

  rsmd_back #(
    .W (W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (!mid_empty),
    .up_pop    (mid_pop),
    .up_kind   (b_kind),
    .up_hi     (b_hi),
    .up_lo     (b_lo),
    .up_div    (b_div),
    .res_valid (r_valid),
    .res_ready (!res_full),
    .res_quot  (r_quot)
  );

  // The result queue keeps the divider moving while a finished result
  // waits to be popped.
  rsmd_queue #(
    .DATA_W (W),
    .DEPTH  (OUT_DEP)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (r_valid),
    .full    (res_full),
    .wr_data (r_quot),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_data)
  );

  assign out_quotient = 32'(res_data);

endmodule

/* hdl/rsmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmd_queue - small synchronous first-in first-out queue
// Register-based storage with a fill count; the head entry is shown
// combinationally while the queue is not empty.
// ----------------------------------------------------------------------------
module rsmd_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/rsmd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmd_front - operand intake, product and classification
// Stage one registers the double-width product and the zero-factor flag.
// Stage two adds half the divisor, checks for overflow and a zero divisor,
// and tags the beat for the back end.
// ----------------------------------------------------------------------------
module rsmd_front #(
  parameter int unsigned W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  input  logic [W-1:0]         d,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rsmd_pkg::kind_t      dn_kind,
  output logic [W-1:0]         dn_hi,
  output logic [W-1:0]         dn_lo,
  output logic [W-1:0]         dn_div
);

  logic             en;
  logic             s1_v_r, s1_v_nxt;
  logic [2*W-1:0]   s1_prod_r;
  logic [W-1:0]     s1_d_r;
  logic             s1_zf_r;
  logic             s2_v_r, s2_v_nxt;
  rsmd_pkg::kind_t  s2_kind_r, s2_kind_nxt;
  logic [2*W-1:0]   s2_biased_r, biased;
  logic [W-1:0]     s2_d_r;

  // The whole front advances together; it holds only when its last stage
  // has a beat the queue cannot take.
  assign en   = !s2_v_r || dn_ready;
  assign full = !en;

  assign s1_v_nxt = push;
  assign s2_v_nxt = s1_v_r;

  always_comb begin
    biased = s1_prod_r + (2*W)'(s1_d_r >> 1);
    if (s1_d_r == '0) begin
      s2_kind_nxt = s1_zf_r ? rsmd_pkg::KIND_ZERO : rsmd_pkg::KIND_ONES;
    end else if (biased[2*W-1:W] >= s1_d_r) begin
      s2_kind_nxt = rsmd_pkg::KIND_ONES;
    end else begin
      s2_kind_nxt = rsmd_pkg::KIND_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r   <= (2*W)'(a) * (2*W)'(b);
      s1_d_r      <= d;
      s1_zf_r     <= (a == '0) || (b == '0);
      s2_kind_r   <= s2_kind_nxt;
      s2_biased_r <= biased;
      s2_d_r      <= s1_d_r;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_kind  = s2_kind_r;
  assign dn_hi    = s2_biased_r[2*W-1:W];
  assign dn_lo    = s2_biased_r[W-1:0];
  assign dn_div   = s2_d_r;

endmodule

/* hdl/rsmd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmd_back - pipelined restoring divider
// One quotient bit per stage, W stages. The forced answers ride along with
// the beat and are selected at the last stage.
// ----------------------------------------------------------------------------
module rsmd_back #(
  parameter int unsigned W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_pop,
  input  rsmd_pkg::kind_t up_kind,
  input  logic [W-1:0]    up_hi,
  input  logic [W-1:0]    up_lo,
  input  logic [W-1:0]    up_div,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [W-1:0]    res_quot
);

  logic            en;
  logic            v_r    [W];
  rsmd_pkg::kind_t kind_r [W];
  logic [W-1:0]    rem_r  [W];
  logic [W-1:0]    lo_r   [W];
  logic [W-1:0]    q_r    [W];
  logic [W-1:0]    d_r    [W];

  logic            v_nxt    [W];
  rsmd_pkg::kind_t kind_nxt [W];
  logic [W-1:0]    rem_nxt  [W];
  logic [W-1:0]    lo_nxt   [W];
  logic [W-1:0]    q_nxt    [W];
  logic [W-1:0]    d_nxt    [W];

  assign en     = !v_r[W-1] || res_ready;
  assign up_pop = en && up_valid;

  // Each stage shifts the next dividend bit into the partial remainder and
  // subtracts the divisor when it fits. The remainder stays below the divisor.
  always_comb begin
    for (int i = 0; i < W; i++) begin
      logic [W-1:0] src_rem, src_lo, src_q, src_d;
      logic [W:0]   trial, diff;
      if (i == 0) begin
        v_nxt[i]    = up_valid;
        kind_nxt[i] = up_kind;
        src_rem     = up_hi;
        src_lo      = up_lo;
        src_q       = '0;
        src_d       = up_div;
      end else begin
        v_nxt[i]    = v_r[i-1];
        kind_nxt[i] = kind_r[i-1];
        src_rem     = rem_r[i-1];
        src_lo      = lo_r[i-1];
        src_q       = q_r[i-1];
        src_d       = d_r[i-1];
      end
      trial = {src_rem, src_lo[W-1]};
      diff  = trial - {1'b0, src_d};
      if (trial >= {1'b0, src_d}) begin
        rem_nxt[i] = diff[W-1:0];
        q_nxt[i]   = {src_q[W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[W-1:0];
        q_nxt[i]   = {src_q[W-2:0], 1'b0};
      end
      lo_nxt[i] = {src_lo[W-2:0], 1'b0};
      d_nxt[i]  = src_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < W; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < W; i++) begin
        v_r[i] <= v_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W; i++) begin
        kind_r[i] <= kind_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        lo_r[i]   <= lo_nxt[i];
        q_r[i]    <= q_nxt[i];
        d_r[i]    <= d_nxt[i];
      end
    end
  end

  assign res_valid = v_r[W-1];

  always_comb begin
    case (kind_r[W-1])
      rsmd_pkg::KIND_DIVIDE: res_quot = q_r[W-1];
      rsmd_pkg::KIND_ZERO:   res_quot = '0;
      rsmd_pkg::KIND_ONES:   res_quot = '1;
      default:               res_quot = '1;
    endcase
  end

endmodule
